// ===== rtl/ilie_pkg.sv =====
// shared types and field widths for the indexed list insert/erase core
package ilie_pkg;

    // fixed widths of the item fields
    localparam int unsigned OP_W   = 3;
    localparam int unsigned POS_W  = 5;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned ST_W   = 2;
    localparam int unsigned CNT_W  = 5;

    // command codes carried by an input item
    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_READ   = 3'd2,
        OP_INSERT = 3'd3,
        OP_ERASE  = 3'd4
    } t_opcode;

    // status codes of a result item
    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // shift command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;  // open a gap at the position and load the new word
        logic era;  // close the gap at the position
    } t_cell_cmd;

endpackage

// ===== rtl/indexed_list_insert_erase_core.sv =====
// top level of the indexed list insert/erase core
//
// Ordered list of up to DEPTH words kept in a chain of cells, one word per
// cell. Each input item (opcode, position, word_in) is one command: push,
// pop, read, insert at index or erase at index. Insert and erase move every
// later word by one place in the same cycle, each cell loading from its
// left or right neighbor.
// Input channel: i_in_valid / o_in_ready. Output channel: o_out_valid /
// i_out_ready. Each accepted item yields exactly one result item (word_out,
// status, where, count) in the output register at the next clock edge.
// Throughput is 1 item per cycle while the receiver takes results, since
// the cell chain shifts in the same cycle that the item is accepted.
// When the receiver stalls, the result stays in the output register and
// o_in_ready drops until it is taken, so no further item is accepted.
// Reset (i_rst_n low, synchronous) empties the list and drops o_out_valid;
// stored words are not cleared, as only positions below the length are read.
module indexed_list_insert_erase_core #(
    parameter int unsigned DEPTH     = 16,
    parameter int unsigned WORD_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [ilie_pkg::OP_W-1:0]    i_opcode,
    input  logic [ilie_pkg::POS_W-1:0]   i_position,
    input  logic [ilie_pkg::WORD_W-1:0]  i_word_in,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [ilie_pkg::WORD_W-1:0]  o_word_out,
    output logic [ilie_pkg::ST_W-1:0]    o_status,
    output logic [ilie_pkg::POS_W-1:0]   o_where,
    output logic [ilie_pkg::CNT_W-1:0]   o_count
);

    localparam int unsigned FW   = $clog2(DEPTH + 1);
    localparam int unsigned PW   = ilie_pkg::POS_W;
    localparam int unsigned CW   = (FW > PW) ? FW : PW;
    localparam int unsigned AW   = $clog2(DEPTH);
    localparam int unsigned OW   = ilie_pkg::WORD_W;
    localparam int unsigned NW   = ilie_pkg::CNT_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    // control and output registers
    logic [FW-1:0]        r_fill;
    logic [FW-1:0]        n_fill;
    logic                 r_out_valid;
    logic [OW-1:0]        r_word;
    logic [OW-1:0]        n_word;
    ilie_pkg::t_status    r_status;
    ilie_pkg::t_status    n_status;
    logic [PW-1:0]        r_where;
    logic [PW-1:0]        n_where;
    logic [NW-1:0]        r_count;

    logic                 w_accept;
    ilie_pkg::t_opcode    w_op;
    logic [CW-1:0]        w_fill;
    logic [CW-1:0]        w_pos;
    logic                 w_full;
    logic [CW-1:0]        w_cell_pos;
    logic [CW-1:0]        w_rd_addr;
    logic                 w_rd_use;
    logic [WORD_BITS-1:0] w_rd_word;
    logic [WORD_BITS-1:0] w_val;
    ilie_pkg::t_cell_cmd  w_cmd;
    logic                 w_do_ins;
    logic                 w_do_era;

    logic [WORD_BITS-1:0] w_slot  [DEPTH];
    logic [WORD_BITS-1:0] w_left  [DEPTH];
    logic [WORD_BITS-1:0] w_right [DEPTH];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_op       = ilie_pkg::t_opcode'(i_opcode);
    assign w_fill     = CW'(r_fill);
    assign w_pos      = CW'(i_position);
    assign w_full     = (w_fill == FULL_CNT);
    assign w_val      = WORD_BITS'(i_word_in);

    // decode the command against the current length
    always_comb begin
        n_fill     = r_fill;
        n_status   = ilie_pkg::ST_RANGE;
        n_where    = i_position;
        w_do_ins   = 1'b0;
        w_do_era   = 1'b0;
        w_cell_pos = w_pos;
        w_rd_addr  = w_pos;
        w_rd_use   = 1'b0;
        unique case (w_op)
            ilie_pkg::OP_PUSH: begin
                n_where    = PW'(w_fill);
                w_cell_pos = w_fill;
                if (w_full) begin
                    n_status = ilie_pkg::ST_FULL;
                end else begin
                    n_status = ilie_pkg::ST_OK;
                    w_do_ins = 1'b1;
                    n_fill   = r_fill + FW'(1);
                end
            end
            ilie_pkg::OP_POP: begin
                if (w_fill == '0) begin
                    n_where = '0;
                end else begin
                    n_status  = ilie_pkg::ST_OK;
                    w_rd_addr = w_fill - CW'(1);
                    w_rd_use  = 1'b1;
                    n_where   = PW'(w_rd_addr);
                    n_fill    = r_fill - FW'(1);
                end
            end
            ilie_pkg::OP_READ: begin
                if (w_pos < w_fill) begin
                    n_status = ilie_pkg::ST_OK;
                    w_rd_use = 1'b1;
                end
            end
            ilie_pkg::OP_INSERT: begin
                if (w_pos > w_fill) begin
                    n_status = ilie_pkg::ST_RANGE;
                end else if (w_full) begin
                    n_status = ilie_pkg::ST_FULL;
                end else begin
                    n_status = ilie_pkg::ST_OK;
                    w_do_ins = 1'b1;
                    n_fill   = r_fill + FW'(1);
                end
            end
            ilie_pkg::OP_ERASE: begin
                if (w_pos < w_fill) begin
                    n_status = ilie_pkg::ST_OK;
                    w_do_era = 1'b1;
                    n_fill   = r_fill - FW'(1);
                end
            end
            default: begin
                n_status = ilie_pkg::ST_RANGE;
            end
        endcase
    end

    // read column over the cells, one address
    assign w_rd_word = w_slot[AW'(w_rd_addr)];

    // returned word is zero unless a pop or read succeeded
    assign n_word = w_rd_use ? OW'(w_rd_word) : '0;

    // shift command goes out only with an accepted item
    assign w_cmd.ins = w_accept && w_do_ins;
    assign w_cmd.era = w_accept && w_do_era;

    // chain of cells with neighbor links
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_left[g] = '0;
        end else begin : g_mid_l
            assign w_left[g] = w_slot[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right[g] = '0;
        end else begin : g_mid_r
            assign w_right[g] = w_slot[g+1];
        end
        ilie_cell #(
            .WORD_BITS (WORD_BITS),
            .CW        (CW),
            .IDX       (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_pos   (w_cell_pos),
            .i_fill  (w_fill),
            .i_val   (w_val),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .o_word  (w_slot[g])
        );
    end

    // length and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_word   <= n_word;
            r_status <= n_status;
            r_where  <= n_where;
            r_count  <= NW'(n_fill);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_word_out  = r_word;
    assign o_status    = r_status;
    assign o_where     = r_where;
    assign o_count     = r_count;

    // length never exceeds the capacity
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_fill) <= FULL_CNT)
        else $error("list length above capacity");

    // a push or insert refused as full only happens at full length
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_status == ilie_pkg::ST_FULL) |-> (r_count == NW'(DEPTH)))
        else $error("full status with list not full");

    // word is zero unless the command succeeded
    a_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_status != ilie_pkg::ST_OK) |-> (r_word == '0))
        else $error("nonzero word on a failed command");

    // accepted push or insert grows the list by one
    a_ins_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.ins |=> (r_fill == $past(r_fill) + FW'(1)))
        else $error("insert did not grow the list");

    // accepted erase shrinks the list by one
    a_era_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.era |=> (r_fill == $past(r_fill) - FW'(1)))
        else $error("erase did not shrink the list");

endmodule

// ===== rtl/ilie_cell.sv =====
// one storage cell of the list chain: holds the word at a fixed index
module ilie_cell #(
    parameter int unsigned WORD_BITS = 32,
    parameter int unsigned CW        = 5,
    parameter int unsigned IDX       = 0
) (
    input  logic                  i_clk,
    input  ilie_pkg::t_cell_cmd   i_cmd,
    input  logic [CW-1:0]         i_pos,
    input  logic [CW-1:0]         i_fill,
    input  logic [WORD_BITS-1:0]  i_val,
    input  logic [WORD_BITS-1:0]  i_left,
    input  logic [WORD_BITS-1:0]  i_right,
    output logic [WORD_BITS-1:0]  o_word
);

    localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
    localparam logic [CW:0]   NXT_IDX = (CW + 1)'(IDX + 1);

    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] n_word;

    // pick the source for this cell from the broadcast command
    always_comb begin
        n_word = r_word;
        if (i_cmd.ins) begin
            if (MY_IDX == i_pos) begin
                n_word = i_val;
            end else if (MY_IDX > i_pos && MY_IDX <= i_fill) begin
                n_word = i_left;
            end
        end else if (i_cmd.era) begin
            if (MY_IDX >= i_pos && NXT_IDX < {1'b0, i_fill}) begin
                n_word = i_right;
            end
        end
    end

    // word register
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for the indexed list insert/erase core
`timescale 1ns / 100ps

module testbench;

    localparam int unsigned DEPTH      = 16;
    localparam int unsigned RAND_ITEMS = 1000;
    localparam int unsigned MAX_GAP    = 10;
    localparam int unsigned RESET_CYC  = 12;
    localparam int unsigned DRAIN_CYC  = 4;
    // highest code the opcode field can carry, outside the defined commands
    localparam logic [ilie_pkg::OP_W-1:0] OP_SPARE_LAST = {ilie_pkg::OP_W{1'b1}};

    // one result item as the core should produce it
    typedef struct packed {
        logic [ilie_pkg::WORD_W-1:0] word;
        ilie_pkg::t_status           status;
        logic [ilie_pkg::POS_W-1:0]  at_pos;
        logic [ilie_pkg::CNT_W-1:0]  count;
    } t_list_result;

    // shadow copy of the list plus the results still owed by the core
    class list_scoreboard;
        logic [ilie_pkg::WORD_W-1:0] slots [DEPTH];
        int unsigned                 fill;
        t_list_result                results_due [$];
        int unsigned                 errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        // apply one accepted command to the shadow list and queue its result
        function void note_command(logic [ilie_pkg::OP_W-1:0] op,
                                   logic [ilie_pkg::POS_W-1:0] pos,
                                   logic [ilie_pkg::WORD_W-1:0] word);
            t_list_result r;
            int unsigned  i;
            r.word   = '0;
            r.status = ilie_pkg::ST_RANGE;
            r.at_pos = pos;
            case (op)
                ilie_pkg::OP_PUSH: begin
                    r.at_pos = ilie_pkg::POS_W'(fill);
                    if (fill >= DEPTH) begin
                        r.status = ilie_pkg::ST_FULL;
                    end else begin
                        slots[fill] = word;
                        fill++;
                        r.status = ilie_pkg::ST_OK;
                    end
                end
                ilie_pkg::OP_POP: begin
                    r.at_pos = '0;
                    if (fill != 0) begin
                        fill--;
                        r.word   = slots[fill];
                        r.status = ilie_pkg::ST_OK;
                        r.at_pos = ilie_pkg::POS_W'(fill);
                    end
                end
                ilie_pkg::OP_READ: begin
                    if (pos < fill) begin
                        r.word   = slots[pos];
                        r.status = ilie_pkg::ST_OK;
                    end
                end
                ilie_pkg::OP_INSERT: begin
                    // an index past the end wins over the full check
                    if (pos <= fill && fill >= DEPTH) begin
                        r.status = ilie_pkg::ST_FULL;
                    end else if (pos <= fill) begin
                        for (i = fill; i > pos; i--)
                            slots[i] = slots[i - 1];
                        slots[pos] = word;
                        fill++;
                        r.status = ilie_pkg::ST_OK;
                    end
                end
                ilie_pkg::OP_ERASE: begin
                    if (pos < fill) begin
                        for (i = pos; i + 1 < fill; i++)
                            slots[i] = slots[i + 1];
                        fill--;
                        r.status = ilie_pkg::ST_OK;
                    end
                end
                default: begin
                    // unknown codes leave the list alone
                end
            endcase
            r.count = ilie_pkg::CNT_W'(fill);
            results_due = {results_due, r};
        endfunction

        task report_mismatch(string field, logic [ilie_pkg::WORD_W-1:0] got,
                             logic [ilie_pkg::WORD_W-1:0] want);
            $display("mismatch on %s at %0t: got %0h, want %0h", field, $time, got, want);
            errors++;
        endtask

        // compare one taken result with the oldest one owed
        task check_result(logic [ilie_pkg::WORD_W-1:0] word,
                          logic [ilie_pkg::ST_W-1:0] status,
                          logic [ilie_pkg::POS_W-1:0] at_pos,
                          logic [ilie_pkg::CNT_W-1:0] count);
            t_list_result want;
            if (results_due.size() == 0) begin
                report_mismatch("result with nothing owed", word, '0);
            end else begin
                want = results_due.pop_front();
                if (word !== want.word)
                    report_mismatch("word_out", word, want.word);
                if (status !== want.status)
                    report_mismatch("status", ilie_pkg::WORD_W'(status),
                                    ilie_pkg::WORD_W'(want.status));
                if (at_pos !== want.at_pos)
                    report_mismatch("where", ilie_pkg::WORD_W'(at_pos),
                                    ilie_pkg::WORD_W'(want.at_pos));
                if (count !== want.count)
                    report_mismatch("count", ilie_pkg::WORD_W'(count),
                                    ilie_pkg::WORD_W'(want.count));
            end
        endtask
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic [ilie_pkg::OP_W-1:0]     i_opcode;
    logic [ilie_pkg::POS_W-1:0]    i_position;
    logic [ilie_pkg::WORD_W-1:0]   i_word_in;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic [ilie_pkg::WORD_W-1:0]   o_word_out;
    logic [ilie_pkg::ST_W-1:0]     o_status;
    logic [ilie_pkg::POS_W-1:0]    o_where;
    logic [ilie_pkg::CNT_W-1:0]    o_count;

    list_scoreboard sb;
    bit             in_calm;
    bit             out_calm;

    indexed_list_insert_erase_core #(
        .DEPTH     (DEPTH),
        .WORD_BITS (ilie_pkg::WORD_W)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_position  (i_position),
        .i_word_in   (i_word_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_word_out  (o_word_out),
        .o_status    (o_status),
        .o_where     (o_where),
        .o_count     (o_count)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // idle cycles before the next handshake, none during a calm stretch
    function automatic int unsigned draw_gap(bit calm);
        return calm ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // offer one command item and hold it until the core takes it
    task automatic send_command(logic [ilie_pkg::OP_W-1:0] op,
                                logic [ilie_pkg::POS_W-1:0] pos,
                                logic [ilie_pkg::WORD_W-1:0] word);
        int unsigned gap;
        if ($urandom_range(0, 39) == 0)
            in_calm = !in_calm;
        gap = draw_gap(in_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_position <= pos;
        i_word_in  <= word;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_command(op, pos, word);
    endtask

    // result side: random stalls between taken items
    initial begin
        int unsigned gap;
        i_out_ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 39) == 0)
                out_calm = !out_calm;
            gap = draw_gap(out_calm);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // check every result item taken at a clock edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_word_out, o_status, o_where, o_count);
    end

    // main stimulus
    initial begin
        int unsigned                 k;
        int unsigned                 roll;
        bit                          shrinking;
        logic [ilie_pkg::OP_W-1:0]   op;
        logic [ilie_pkg::POS_W-1:0]  pos;
        logic [ilie_pkg::WORD_W-1:0] word;
        sb = new();
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_opcode   <= ilie_pkg::OP_PUSH;
        i_position <= '0;
        i_word_in  <= '0;
        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list: pop, read, erase and an insert past the end are refused
        send_command(ilie_pkg::OP_POP, '0, '1);
        send_command(ilie_pkg::OP_READ, '0, '0);
        send_command(ilie_pkg::OP_ERASE, '0, '0);
        send_command(ilie_pkg::OP_INSERT, ilie_pkg::POS_W'(1), $urandom);

        // fill up with pushes and inserts at the front, the end and the middle
        for (k = 0; k < DEPTH; k++) begin
            if (k == 0)
                word = '1;
            else if (k == 1)
                word = '0;
            else
                word = $urandom;
            case (k % 4)
                0: send_command(ilie_pkg::OP_PUSH, '0, word);
                1: send_command(ilie_pkg::OP_INSERT, '0, word);
                2: send_command(ilie_pkg::OP_INSERT, ilie_pkg::POS_W'(sb.fill), word);
                default: send_command(ilie_pkg::OP_INSERT,
                                      ilie_pkg::POS_W'(sb.fill / 2), word);
            endcase
        end

        // full list: refusals, an index past the end, reads, then erase, pop and an unknown code
        send_command(ilie_pkg::OP_PUSH, '0, $urandom);
        send_command(ilie_pkg::OP_INSERT, ilie_pkg::POS_W'(DEPTH / 2), $urandom);
        send_command(ilie_pkg::OP_INSERT, ilie_pkg::POS_W'(DEPTH + 1), $urandom);
        send_command(ilie_pkg::OP_READ, ilie_pkg::POS_W'(DEPTH - 1), '0);
        send_command(ilie_pkg::OP_READ, '1, '0);
        send_command(ilie_pkg::OP_ERASE, ilie_pkg::POS_W'(DEPTH - 1), '0);
        send_command(ilie_pkg::OP_ERASE, '0, '0);
        send_command(ilie_pkg::OP_POP, '0, '0);
        send_command(OP_SPARE_LAST, '1, '1);

        // random part: grow toward full, then shrink toward empty, and again
        shrinking = 1'b0;
        repeat (RAND_ITEMS) begin
            if (sb.fill == DEPTH && $urandom_range(0, 3) == 0)
                shrinking = 1'b1;
            else if (sb.fill == 0 && $urandom_range(0, 3) == 0)
                shrinking = 1'b0;

            roll = $urandom_range(0, 99);
            if (roll < 3)
                op = ilie_pkg::OP_W'($urandom_range(ilie_pkg::OP_ERASE + 1, OP_SPARE_LAST));
            else if (roll < 33)
                op = shrinking ? ilie_pkg::OP_POP : ilie_pkg::OP_PUSH;
            else if (roll < 68)
                op = shrinking ? ilie_pkg::OP_ERASE : ilie_pkg::OP_INSERT;
            else if (roll < 83)
                op = ilie_pkg::OP_READ;
            else if (roll < 91)
                op = shrinking ? ilie_pkg::OP_PUSH : ilie_pkg::OP_POP;
            else
                op = shrinking ? ilie_pkg::OP_INSERT : ilie_pkg::OP_ERASE;

            // mostly a legal index, now and then anything the field holds
            if ($urandom_range(0, 7) == 0)
                pos = ilie_pkg::POS_W'($urandom_range(0, (1 << ilie_pkg::POS_W) - 1));
            else if (op == ilie_pkg::OP_INSERT)
                pos = ilie_pkg::POS_W'($urandom_range(0, sb.fill));
            else if (sb.fill > 0)
                pos = ilie_pkg::POS_W'($urandom_range(0, sb.fill - 1));
            else
                pos = '0;

            roll = $urandom_range(0, 7);
            if (roll == 0)
                word = '0;
            else if (roll == 1)
                word = '1;
            else
                word = $urandom;

            send_command(op, pos, word);
        end
        i_in_valid <= 1'b0;

        // drain the results still owed, then a few quiet cycles
        while (sb.results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #1000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
